/* rtl/quad_pd_motor_mixer_macros.svh */
// ----------------------------------------------------------------------------
// quad_pd_motor_mixer assertion macros
// shared forms for the concurrent checks of the motor mixer, clocked on clk
// and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef QUAD_PD_MOTOR_MIXER_MACROS_SVH
`define QUAD_PD_MOTOR_MIXER_MACROS_SVH

// consequent checked in the same cycle
`define QPMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define QPMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/qpmm_pkg.sv */
// ----------------------------------------------------------------------------
// qpmm_pkg
// types, widths, register codes and the pwm clamp of the motor mixer
// ----------------------------------------------------------------------------
`default_nettype none

package qpmm_pkg;

  localparam int ANGLE_W = 9;
  localparam int GYRO_W  = 16;
  localparam int STICK_W = 8;
  localparam int KGAIN_W = 10;
  localparam int SGAIN_W = 8;
  localparam int PWM_W   = 16;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 16;

  // pd term: 17 bit difference times 10 bit gain plus 16 bit value times gain
  localparam int PD_W    = 28;
  // centered stick times 8 bit gain
  localparam int STEER_W = 17;
  // base plus centered throttle times gain
  localparam int COMM_W  = 18;
  localparam int YAW_SH  = 4;
  // room for five signed terms of up to PD_W bits
  localparam int SUM_W   = 31;

  localparam logic [STICK_W:0] STICK_CENTRE = (STICK_W+1)'(128);
  localparam logic [PWM_W-1:0] PWM_MAX      = '1;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [GYRO_W-1:0]  gyro_t;
  typedef logic [STICK_W-1:0]        stick_t;
  typedef logic [KGAIN_W-1:0]        kgain_t;
  typedef logic [SGAIN_W-1:0]        sgain_t;
  typedef logic [PWM_W-1:0]          pwm_t;
  typedef logic signed [PD_W-1:0]    pd_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_ANGLE_KP      = 3'd0,
    REG_ANGLE_KD      = 3'd1,
    REG_RATE_KP       = 3'd2,
    REG_RATE_KD       = 3'd3,
    REG_PWM_BASE      = 3'd4,
    REG_PWM_FLOOR     = 3'd5,
    REG_THROTTLE_GAIN = 3'd6,
    REG_STEER_GAIN    = 3'd7
  } cfg_reg_t;

  // floor first, then saturate at full scale
  function automatic pwm_t clamp_pwm(input sum_t sum, input pwm_t floor_val);
    sum_t lo;
    sum_t hi;
    lo = sum_t'({1'b0, floor_val});
    hi = sum_t'({1'b0, PWM_MAX});
    if (sum < lo) begin
      return floor_val;
    end else if (sum > hi) begin
      return PWM_MAX;
    end else begin
      return sum[PWM_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/qpmm_in_if.sv */
// ----------------------------------------------------------------------------
// qpmm_in_if
// sample channel of the motor mixer: sensor values and stick bytes
// ----------------------------------------------------------------------------
`default_nettype none

interface qpmm_in_if;
  import qpmm_pkg::*;

  logic   valid;
  logic   ready;
  angle_t angle_x;
  angle_t angle_y;
  gyro_t  gyro_x;
  gyro_t  gyro_y;
  gyro_t  gyro_z;
  stick_t throttle;
  stick_t move_x;
  stick_t move_y;

  modport source (
    output valid, angle_x, angle_y, gyro_x, gyro_y, gyro_z, throttle, move_x, move_y,
    input  ready
  );

  modport sink (
    input  valid, angle_x, angle_y, gyro_x, gyro_y, gyro_z, throttle, move_x, move_y,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/qpmm_out_if.sv */
// ----------------------------------------------------------------------------
// qpmm_out_if
// result channel of the motor mixer: four motor pwm values
// ----------------------------------------------------------------------------
`default_nettype none

interface qpmm_out_if;
  import qpmm_pkg::*;

  logic valid;
  logic ready;
  pwm_t pwm_left;
  pwm_t pwm_right;
  pwm_t pwm_front;
  pwm_t pwm_back;

  modport source (
    output valid, pwm_left, pwm_right, pwm_front, pwm_back,
    input  ready
  );

  modport sink (
    input  valid, pwm_left, pwm_right, pwm_front, pwm_back,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/quad_pd_motor_mixer.sv */
// ----------------------------------------------------------------------------
// quad_pd_motor_mixer
// an accepted sample becomes a pwm word through the stage 1, 2 and 3 registers
// throughput: one sample per cycle while out_ch.ready does not stall the three-stage multiply/mix pipe
// reset (synchronous, rst_n low): gains, base, floor and previous samples to
// zero, pipeline empty; the previous samples advance on each accepted word
// ----------------------------------------------------------------------------
`default_nettype none

`include "quad_pd_motor_mixer_macros.svh"

module quad_pd_motor_mixer (
  input  logic                              clk,
  input  logic                              rst_n,
  qpmm_in_if.sink                           in_ch,
  qpmm_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  qpmm_pkg::cfg_reg_t                cfg_idx,
  input  logic [qpmm_pkg::CFG_DW-1:0]       cfg_wdata
);
  import qpmm_pkg::*;

  // configuration
  kgain_t angle_kp_r, angle_kd_r, rate_kp_r, rate_kd_r;
  pwm_t   pwm_base_r, pwm_floor_r;
  sgain_t throttle_gain_r, steer_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_kp_r      <= '0;
      angle_kd_r      <= '0;
      rate_kp_r       <= '0;
      rate_kd_r       <= '0;
      pwm_base_r      <= '0;
      pwm_floor_r     <= '0;
      throttle_gain_r <= '0;
      steer_gain_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ANGLE_KP:      angle_kp_r      <= cfg_wdata[KGAIN_W-1:0];
        REG_ANGLE_KD:      angle_kd_r      <= cfg_wdata[KGAIN_W-1:0];
        REG_RATE_KP:       rate_kp_r       <= cfg_wdata[KGAIN_W-1:0];
        REG_RATE_KD:       rate_kd_r       <= cfg_wdata[KGAIN_W-1:0];
        REG_PWM_BASE:      pwm_base_r      <= cfg_wdata[PWM_W-1:0];
        REG_PWM_FLOOR:     pwm_floor_r     <= cfg_wdata[PWM_W-1:0];
        REG_THROTTLE_GAIN: throttle_gain_r <= cfg_wdata[SGAIN_W-1:0];
        REG_STEER_GAIN:    steer_gain_r    <= cfg_wdata[SGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow: a stage loads when it is empty or its content moves on
  logic s1_vld_r, s2_vld_r, out_vld_r;
  logic out_en, s2_en, s1_en, in_acc;

  assign out_en = !out_vld_r || out_ch.ready;
  assign s2_en  = !s2_vld_r || out_en;
  assign s1_en  = !s1_vld_r || s2_en;
  assign in_acc = in_ch.valid && s1_en;

  assign in_ch.ready  = s1_en;
  assign out_ch.valid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_vld_r <= in_ch.valid;
      end
      if (s2_en) begin
        s2_vld_r <= s1_vld_r;
      end
      if (out_en) begin
        out_vld_r <= s2_vld_r;
      end
    end
  end

  // previous samples, advanced on every accepted word
  angle_t prev_ax_r, prev_ay_r;
  gyro_t  prev_gx_r, prev_gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ax_r <= '0;
      prev_ay_r <= '0;
      prev_gx_r <= '0;
      prev_gy_r <= '0;
    end else if (in_acc) begin
      prev_ax_r <= in_ch.angle_x;
      prev_ay_r <= in_ch.angle_y;
      prev_gx_r <= in_ch.gyro_x;
      prev_gy_r <= in_ch.gyro_y;
    end
  end

  // stage 1: register sample, differences and centered sticks
  gyro_t                    ax_s1_r, ay_s1_r, gx_s1_r, gy_s1_r, gz_s1_r;
  logic signed [GYRO_W:0]   dax_s1_r, day_s1_r, dgx_s1_r, dgy_s1_r;
  logic signed [STICK_W:0]  thr_s1_r, mx_s1_r, my_s1_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_s1_r  <= GYRO_W'(in_ch.angle_x);
      ay_s1_r  <= GYRO_W'(in_ch.angle_y);
      gx_s1_r  <= in_ch.gyro_x;
      gy_s1_r  <= in_ch.gyro_y;
      gz_s1_r  <= in_ch.gyro_z;
      dax_s1_r <= (GYRO_W+1)'(prev_ax_r) - (GYRO_W+1)'(in_ch.angle_x);
      day_s1_r <= (GYRO_W+1)'(prev_ay_r) - (GYRO_W+1)'(in_ch.angle_y);
      dgx_s1_r <= (GYRO_W+1)'(prev_gx_r) - (GYRO_W+1)'(in_ch.gyro_x);
      dgy_s1_r <= (GYRO_W+1)'(prev_gy_r) - (GYRO_W+1)'(in_ch.gyro_y);
      thr_s1_r <= $signed({1'b0, in_ch.throttle} - STICK_CENTRE);
      mx_s1_r  <= $signed({1'b0, in_ch.move_x} - STICK_CENTRE);
      my_s1_r  <= $signed({1'b0, in_ch.move_y} - STICK_CENTRE);
    end
  end

  // stage 2: products
  pd_t pax_s2_r, pay_s2_r, pgx_s2_r, pgy_s2_r;

  qpmm_pd u_pd_ax (
    .clk(clk), .en(s2_en), .cur(ax_s1_r), .diff(dax_s1_r),
    .kp(angle_kp_r), .kd(angle_kd_r), .term_r(pax_s2_r)
  );
  qpmm_pd u_pd_ay (
    .clk(clk), .en(s2_en), .cur(ay_s1_r), .diff(day_s1_r),
    .kp(angle_kp_r), .kd(angle_kd_r), .term_r(pay_s2_r)
  );
  qpmm_pd u_pd_gx (
    .clk(clk), .en(s2_en), .cur(gx_s1_r), .diff(dgx_s1_r),
    .kp(rate_kp_r), .kd(rate_kd_r), .term_r(pgx_s2_r)
  );
  qpmm_pd u_pd_gy (
    .clk(clk), .en(s2_en), .cur(gy_s1_r), .diff(dgy_s1_r),
    .kp(rate_kp_r), .kd(rate_kd_r), .term_r(pgy_s2_r)
  );

  logic signed [COMM_W-1:0]  common_s2_r, common_nxt;
  logic signed [STEER_W-1:0] sx_s2_r, sy_s2_r, sx_nxt, sy_nxt;
  gyro_t                     gz_s2_r;

  assign common_nxt = COMM_W'($signed({1'b0, pwm_base_r}))
                    + COMM_W'(thr_s1_r) * COMM_W'($signed({1'b0, throttle_gain_r}));
  assign sx_nxt = STEER_W'(mx_s1_r) * STEER_W'($signed({1'b0, steer_gain_r}));
  assign sy_nxt = STEER_W'(my_s1_r) * STEER_W'($signed({1'b0, steer_gain_r}));

  always_ff @(posedge clk) begin
    if (s2_en) begin
      common_s2_r <= common_nxt;
      sx_s2_r     <= sx_nxt;
      sy_s2_r     <= sy_nxt;
      gz_s2_r     <= gz_s1_r;
    end
  end

  // stage 3: plus-frame mix and clamp
  sum_t comm_e, sx_e, sy_e, yaw_e, ax_e, ay_e, gx_e, gy_e;
  sum_t left_sum, right_sum, front_sum, back_sum;
  pwm_t pwm_left_r, pwm_right_r, pwm_front_r, pwm_back_r;

  assign comm_e = SUM_W'(common_s2_r);
  assign sx_e   = SUM_W'(sx_s2_r);
  assign sy_e   = SUM_W'(sy_s2_r);
  assign yaw_e  = SUM_W'(gz_s2_r) <<< YAW_SH;
  assign ax_e   = SUM_W'(pax_s2_r);
  assign ay_e   = SUM_W'(pay_s2_r);
  assign gx_e   = SUM_W'(pgx_s2_r);
  assign gy_e   = SUM_W'(pgy_s2_r);

  assign left_sum  = comm_e + sx_e - ax_e - gx_e - yaw_e;
  assign right_sum = comm_e - sx_e + ax_e + gx_e - yaw_e;
  assign front_sum = comm_e - sy_e - ay_e + gy_e + yaw_e;
  assign back_sum  = comm_e + sy_e + ay_e - gy_e + yaw_e;

  always_ff @(posedge clk) begin
    if (out_en) begin
      pwm_left_r  <= clamp_pwm(left_sum, pwm_floor_r);
      pwm_right_r <= clamp_pwm(right_sum, pwm_floor_r);
      pwm_front_r <= clamp_pwm(front_sum, pwm_floor_r);
      pwm_back_r  <= clamp_pwm(back_sum, pwm_floor_r);
    end
  end

  assign out_ch.pwm_left  = pwm_left_r;
  assign out_ch.pwm_right = pwm_right_r;
  assign out_ch.pwm_front = pwm_front_r;
  assign out_ch.pwm_back  = pwm_back_r;

  // checks
  `QPMM_ASSERT_NEXT(a_acc_fills_s1, in_ch.valid && in_ch.ready, s1_vld_r, "accepted word not in stage 1")
  `QPMM_ASSERT_NEXT(a_stall_holds, out_vld_r && !out_ch.ready && s2_vld_r, out_vld_r && s2_vld_r, "word lost in stall")
  `QPMM_ASSERT_NOW(a_out_drop, $fell(out_vld_r), $past(out_ch.ready), "result dropped without handshake")

endmodule

`default_nettype wire

/* rtl/qpmm_pd.sv */
// ----------------------------------------------------------------------------
// qpmm_pd
// one registered pd term: value*kp + (previous - value)*kd
// ----------------------------------------------------------------------------
`default_nettype none

module qpmm_pd (
  input  logic                         clk,
  input  logic                         en,
  input  qpmm_pkg::gyro_t              cur,
  input  logic signed [qpmm_pkg::GYRO_W:0] diff,
  input  qpmm_pkg::kgain_t             kp,
  input  qpmm_pkg::kgain_t             kd,
  output qpmm_pkg::pd_t                term_r
);
  import qpmm_pkg::*;

  pd_t cur_ext;
  pd_t diff_ext;
  pd_t kp_ext;
  pd_t kd_ext;
  pd_t term_nxt;

  assign cur_ext  = PD_W'(cur);
  assign diff_ext = PD_W'(diff);
  assign kp_ext   = PD_W'($signed({1'b0, kp}));
  assign kd_ext   = PD_W'($signed({1'b0, kd}));
  assign term_nxt = cur_ext * kp_ext + diff_ext * kd_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
    end
  end

endmodule

`default_nettype wire

/* sim/qpmm_mix_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpmm_mix_checker
// watches the sample, pwm and register ports of the motor mixer, predicts the
// four motor values of every accepted sample and compares them, in order,
// with the pwm words that leave the block
// ----------------------------------------------------------------------------
module qpmm_mix_checker
  import qpmm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  qpmm_in_if                in_mon,
  qpmm_out_if               out_mon,
  input  logic              cfg_we,
  input  cfg_reg_t          cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                fail_count,
  output int                words_pending
);

  localparam longint STICK_MID = 128;
  localparam longint YAW_GAIN  = 16;
  localparam int     MAX_SHOWN = 10;

  typedef struct packed {
    pwm_t left;
    pwm_t right;
    pwm_t front;
    pwm_t back;
  } motor_word_t;

  kgain_t angle_kp, angle_kd, rate_kp, rate_kd;
  pwm_t   pwm_base, pwm_floor;
  sgain_t throttle_gain, steer_gain;

  angle_t last_angle_x, last_angle_y;
  gyro_t  last_gyro_x, last_gyro_y;

  motor_word_t pwm_expected[$];
  int          shown;

  function automatic pwm_t floor_and_saturate(longint sum);
    if (sum < longint'(pwm_floor)) begin
      return pwm_floor;
    end
    if (sum > longint'(PWM_MAX)) begin
      return PWM_MAX;
    end
    return pwm_t'(sum);
  endfunction

  function automatic longint pd_correction(longint cur, longint last, kgain_t kp, kgain_t kd);
    return cur * longint'(kp) + (last - cur) * longint'(kd);
  endfunction

  always @(posedge clk) begin : watch
    longint      ax, ay, gx, gy, gz;
    longint      common, sx, sy, yaw, pd_ax, pd_ay, pd_gx, pd_gy;
    motor_word_t want, got;
    if (!rst_n) begin
      angle_kp      = '0;
      angle_kd      = '0;
      rate_kp       = '0;
      rate_kd       = '0;
      pwm_base      = '0;
      pwm_floor     = '0;
      throttle_gain = '0;
      steer_gain    = '0;
      last_angle_x  = '0;
      last_angle_y  = '0;
      last_gyro_x   = '0;
      last_gyro_y   = '0;
      pwm_expected.delete();
      shown         = 0;
      fail_count    = 0;
      words_pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_ANGLE_KP:      angle_kp      = cfg_wdata[KGAIN_W-1:0];
          REG_ANGLE_KD:      angle_kd      = cfg_wdata[KGAIN_W-1:0];
          REG_RATE_KP:       rate_kp       = cfg_wdata[KGAIN_W-1:0];
          REG_RATE_KD:       rate_kd       = cfg_wdata[KGAIN_W-1:0];
          REG_PWM_BASE:      pwm_base      = cfg_wdata[PWM_W-1:0];
          REG_PWM_FLOOR:     pwm_floor     = cfg_wdata[PWM_W-1:0];
          REG_THROTTLE_GAIN: throttle_gain = cfg_wdata[SGAIN_W-1:0];
          REG_STEER_GAIN:    steer_gain    = cfg_wdata[SGAIN_W-1:0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        ax = in_mon.angle_x;
        ay = in_mon.angle_y;
        gx = in_mon.gyro_x;
        gy = in_mon.gyro_y;
        gz = in_mon.gyro_z;
        pd_ax = pd_correction(ax, last_angle_x, angle_kp, angle_kd);
        pd_ay = pd_correction(ay, last_angle_y, angle_kp, angle_kd);
        pd_gx = pd_correction(gx, last_gyro_x, rate_kp, rate_kd);
        pd_gy = pd_correction(gy, last_gyro_y, rate_kp, rate_kd);
        common = longint'(pwm_base)
               + (longint'(in_mon.throttle) - STICK_MID) * longint'(throttle_gain);
        sx  = (longint'(in_mon.move_x) - STICK_MID) * longint'(steer_gain);
        sy  = (longint'(in_mon.move_y) - STICK_MID) * longint'(steer_gain);
        yaw = gz * YAW_GAIN;
        want.left  = floor_and_saturate(common + sx - pd_ax - pd_gx - yaw);
        want.right = floor_and_saturate(common - sx + pd_ax + pd_gx - yaw);
        want.front = floor_and_saturate(common - sy - pd_ay + pd_gy + yaw);
        want.back  = floor_and_saturate(common + sy + pd_ay - pd_gy + yaw);
        pwm_expected.push_back(want);
        last_angle_x = in_mon.angle_x;
        last_angle_y = in_mon.angle_y;
        last_gyro_x  = in_mon.gyro_x;
        last_gyro_y  = in_mon.gyro_y;
      end

      if (out_mon.valid && out_mon.ready) begin
        got.left  = out_mon.pwm_left;
        got.right = out_mon.pwm_right;
        got.front = out_mon.pwm_front;
        got.back  = out_mon.pwm_back;
        if (pwm_expected.size() == 0) begin
          fail_count++;
          if (shown < MAX_SHOWN) begin
            $display("%0t: pwm word with nothing expected: l=%0d r=%0d f=%0d b=%0d",
                     $time, got.left, got.right, got.front, got.back);
          end
          shown++;
        end else begin
          want = pwm_expected.pop_front();
          if (got !== want) begin
            fail_count++;
            if (shown < MAX_SHOWN) begin
              $display("%0t: pwm mismatch: expected l=%0d r=%0d f=%0d b=%0d",
                       $time, want.left, want.right, want.front, want.back);
              $display("%0t:               got      l=%0d r=%0d f=%0d b=%0d",
                       $time, got.left, got.right, got.front, got.back);
            end
            shown++;
          end
        end
      end

      words_pending = pwm_expected.size();
    end
  end

endmodule

/* sim/quad_pd_motor_mixer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_pd_motor_mixer_tb
// drives sensor and stick samples into the motor mixer under several register
// settings and idle patterns, with one long output hold-off; the checker
// beside the block predicts every pwm word and counts failures
// ----------------------------------------------------------------------------
module quad_pd_motor_mixer_tb;
  import qpmm_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int PHASE_WORDS     = 105;
  localparam int RANDOM_PHASES   = 8;
  localparam int TAIL_CYCLES     = 10;

  typedef struct packed {
    kgain_t angle_kp;
    kgain_t angle_kd;
    kgain_t rate_kp;
    kgain_t rate_kd;
    pwm_t   pwm_base;
    pwm_t   pwm_floor;
    sgain_t throttle_gain;
    sgain_t steer_gain;
  } mixer_cfg_t;

  typedef struct packed {
    angle_t ax;
    angle_t ay;
    gyro_t  gx;
    gyro_t  gy;
    gyro_t  gz;
    stick_t thr;
    stick_t mx;
    stick_t my;
  } sample_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  cfg_reg_t          cfg_idx;
  logic [CFG_DW-1:0] cfg_wdata;

  int src_idle_pct;
  int rcv_stall_pct;
  bit hold_req;
  int fail_count;
  int words_pending;
  int quiet_cycles;

  qpmm_in_if  in_ch ();
  qpmm_out_if out_ch ();

  quad_pd_motor_mixer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  qpmm_mix_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic sample_t make_sample(int ax, int ay, int gx, int gy, int gz,
                                          int thr, int mx, int my);
    sample_t s;
    s.ax  = angle_t'(ax);
    s.ay  = angle_t'(ay);
    s.gx  = gyro_t'(gx);
    s.gy  = gyro_t'(gy);
    s.gz  = gyro_t'(gz);
    s.thr = stick_t'(thr);
    s.mx  = stick_t'(mx);
    s.my  = stick_t'(my);
    return s;
  endfunction

  function automatic kgain_t pick_kgain();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return kgain_t'($urandom_range(15));
      default: return kgain_t'($urandom);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.angle_x  <= s.ax;
    in_ch.angle_y  <= s.ay;
    in_ch.gyro_x   <= s.gx;
    in_ch.gyro_y   <= s.gy;
    in_ch.gyro_z   <= s.gz;
    in_ch.throttle <= s.thr;
    in_ch.move_x   <= s.mx;
    in_ch.move_y   <= s.my;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  // writes every register once, in index order, on back-to-back cycles
  task automatic write_config(input mixer_cfg_t c);
    cfg_reg_t          r;
    logic [CFG_DW-1:0] v;
    r = r.first();
    do begin
      case (r)
        REG_ANGLE_KP:      v = CFG_DW'(c.angle_kp);
        REG_ANGLE_KD:      v = CFG_DW'(c.angle_kd);
        REG_RATE_KP:       v = CFG_DW'(c.rate_kp);
        REG_RATE_KD:       v = CFG_DW'(c.rate_kd);
        REG_PWM_BASE:      v = CFG_DW'(c.pwm_base);
        REG_PWM_FLOOR:     v = CFG_DW'(c.pwm_floor);
        REG_THROTTLE_GAIN: v = CFG_DW'(c.throttle_gain);
        default:           v = CFG_DW'(c.steer_gain);
      endcase
      cfg_we    <= 1'b1;
      cfg_idx   <= r;
      cfg_wdata <= v;
      @(negedge clk);
      r = r.next();
    end while (r != r.first());
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, or one long hold-off when asked
  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("quad_pd_motor_mixer_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    mixer_cfg_t c;
    sample_t    s;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_ANGLE_KP;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.angle_x  = '0;
    in_ch.angle_y  = '0;
    in_ch.gyro_x   = '0;
    in_ch.gyro_y   = '0;
    in_ch.gyro_z   = '0;
    in_ch.throttle = '0;
    in_ch.move_x   = '0;
    in_ch.move_y   = '0;
    src_idle_pct   = 0;
    rcv_stall_pct  = 0;
    hold_req       = 1'b0;
    // drift starts from a known sample
    s              = '0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // registers still at reset: only the yaw term reaches the motors
    send_sample(make_sample(0, 0, 0, 0, -32768, 128, 128, 128));
    send_sample(make_sample(255, -256, 32767, -32768, 32767, 255, 0, 255));
    send_sample(make_sample(-180, 180, -1, 1, 1, 0, 255, 0));
    wait_drained();

    c = '{angle_kp: 10'd3, angle_kd: 10'd2, rate_kp: 10'd1, rate_kd: 10'd1,
          pwm_base: 16'd32768, pwm_floor: 16'd1000,
          throttle_gain: 8'd40, steer_gain: 8'd30};
    write_config(c);
    send_sample(make_sample(0, 0, 0, 0, 0, 128, 128, 128));
    send_sample(make_sample(180, -180, 0, 0, 0, 128, 128, 128));
    send_sample(make_sample(-180, 180, 0, 0, 0, 128, 128, 128));
    // angles outside the physical range pass as 9 bit values
    send_sample(make_sample(255, -256, 0, 0, 0, 128, 128, 128));
    send_sample(make_sample(-256, 255, 32767, -32768, 0, 128, 128, 128));
    send_sample(make_sample(0, 0, -32768, 32767, -32768, 128, 128, 128));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(make_sample(0, 0, 0, 0, 0, 255, 255, 255));
    send_sample(make_sample(10, -10, 200, -200, 50, 128, 140, 116));
    // same sample again: derivative terms vanish
    send_sample(make_sample(10, -10, 200, -200, 50, 128, 140, 116));
    send_sample(make_sample(-10, 10, -200, 200, -50, 100, 90, 170));
    send_sample(make_sample(0, 0, 0, 0, 2000, 128, 128, 128));
    send_sample(make_sample(0, 0, 0, 0, -2000, 128, 128, 128));
    send_sample(make_sample(-1, -1, -1, -1, -1, 127, 127, 127));
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0:       begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
        1:       begin src_idle_pct = 83; rcv_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  rcv_stall_pct = 83; end
        default: begin src_idle_pct = 24; rcv_stall_pct = 24; end
      endcase
      if (ph == 0) begin
        c = '1;
      end else if (ph == 1) begin
        c = '0;
      end else begin
        c.angle_kp      = pick_kgain();
        c.angle_kd      = pick_kgain();
        c.rate_kp       = pick_kgain();
        c.rate_kd       = pick_kgain();
        c.pwm_base      = ($urandom_range(5) == 0) ? pwm_t'($urandom)
                                                    : pwm_t'($urandom_range(45000, 20000));
        c.pwm_floor     = ($urandom_range(5) == 0) ? pwm_t'($urandom)
                                                    : pwm_t'($urandom_range(20000));
        c.throttle_gain = sgain_t'($urandom);
        c.steer_gain    = sgain_t'($urandom);
      end
      write_config(c);
      // no idling on either side here, so the long hold-off backs the block up
      if (ph == 4) begin
        hold_req = 1'b1;
      end
      repeat (PHASE_WORDS) begin
        case ($urandom_range(9))
          0, 1: begin
            s.ax = angle_t'($urandom);
            s.ay = angle_t'($urandom);
            s.gx = gyro_t'($urandom);
            s.gy = gyro_t'($urandom);
            s.gz = gyro_t'($urandom);
          end
          // slow drift from the last sample, as a real sensor would move
          2, 3, 4: begin
            s.ax = s.ax + angle_t'(int'($urandom_range(6)) - 3);
            s.ay = s.ay + angle_t'(int'($urandom_range(6)) - 3);
            s.gx = s.gx + gyro_t'(int'($urandom_range(64)) - 32);
            s.gy = s.gy + gyro_t'(int'($urandom_range(64)) - 32);
            s.gz = s.gz + gyro_t'(int'($urandom_range(64)) - 32);
          end
          default: begin
            s.ax = angle_t'(int'($urandom_range(360)) - 180);
            s.ay = angle_t'(int'($urandom_range(360)) - 180);
            s.gx = gyro_t'(int'($urandom_range(1000)) - 500);
            s.gy = gyro_t'(int'($urandom_range(1000)) - 500);
            s.gz = gyro_t'(int'($urandom_range(1000)) - 500);
          end
        endcase
        s.thr = stick_t'($urandom);
        s.mx  = stick_t'($urandom);
        s.my  = stick_t'($urandom);
        send_sample(s);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("quad_pd_motor_mixer_tb: PASS");
    end else begin
      $display("quad_pd_motor_mixer_tb: FAIL");
    end
    $finish;
  end

endmodule
